/* hdl/adjacent_step_sequence_counter_top_macros.svh */
// Assertion macros shared by the adjacent step sequence counter modules.
`ifndef ADJACENT_STEP_SEQUENCE_COUNTER_TOP_MACROS_SVH
`define ADJACENT_STEP_SEQUENCE_COUNTER_TOP_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSC_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the following cycle.
`define ASSC_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/assc_pkg.sv */
// Package with shared types, constants and modular arithmetic for the counter.
package assc_pkg;

    localparam int COUNT_W = 30;
    localparam int VALUE_W = 8;
    localparam int OUT_TDATA_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_MOD = 30'd1000000007;
    localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 8'd100;

    typedef struct packed {
        logic start;
        logic seed;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

    function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        logic [COUNT_W:0] p;
        p = {1'b0, COUNT_MOD};
        s = {1'b0, a} + {1'b0, b};
        return (s >= p) ? COUNT_W'(s - p) : s[COUNT_W-1:0];
    endfunction

endpackage

/* hdl/assc_datapath.sv */
// Datapath: count memory, sliding three-entry window, reduction stages and total.
`include "adjacent_step_sequence_counter_top_macros.svh"

module assc_datapath #(
    parameter int MAX_VALUE = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [assc_pkg::VALUE_W-1:0]  cfg_wdata,
    input  logic [assc_pkg::VALUE_W-1:0]  template_value,
    input  assc_pkg::cmd_t                cmd,
    output assc_pkg::status_t             status,
    output logic [assc_pkg::COUNT_W-1:0]  array_count
);

    localparam int AW = $clog2(MAX_VALUE);
    localparam int BW = $clog2(MAX_VALUE + 1);
    localparam int CW = (BW > assc_pkg::VALUE_W) ? BW : assc_pkg::VALUE_W;

    logic [assc_pkg::COUNT_W-1:0] mem [MAX_VALUE];

    logic [assc_pkg::VALUE_W-1:0] max_value_reg;
    logic [assc_pkg::VALUE_W-1:0] fixed_reg;
    logic [BW-1:0]                bound_reg;
    logic [BW-1:0]                bound_now;

    logic                         rd_active_reg;
    logic [BW-1:0]                rd_idx_reg;
    logic [assc_pkg::COUNT_W-1:0] rdata_reg;

    logic                         s1_valid_reg;
    logic [BW-1:0]                s1_idx_reg;
    logic [assc_pkg::COUNT_W-1:0] cur_reg;
    logic [assc_pkg::COUNT_W-1:0] prev_reg;

    logic                         a_valid_reg;
    logic [AW-1:0]                a_j_reg;
    logic [assc_pkg::COUNT_W-1:0] a_t_reg;
    logic [assc_pkg::COUNT_W-1:0] a_p_reg;

    logic                         c_valid_reg;
    logic                         c_last_reg;
    logic [assc_pkg::COUNT_W-1:0] c_fresh_reg;

    logic [assc_pkg::COUNT_W-1:0] total_reg;
    logic [assc_pkg::COUNT_W-1:0] count_out_reg;

    logic [BW-1:0]                b_v;
    logic                         b_allowed;
    logic [assc_pkg::COUNT_W-1:0] b_fresh;

    assign bound_now = (32'(max_value_reg) > 32'(MAX_VALUE)) ? BW'(MAX_VALUE)
                                                             : BW'(max_value_reg);

    assign b_v = BW'(a_j_reg) + BW'(1);
    assign b_allowed = (b_v <= bound_reg) &&
                       ((fixed_reg == '0) || (CW'(fixed_reg) == CW'(b_v)));

    always_comb
    begin
        if (!b_allowed)
        begin
            b_fresh = '0;
        end
        else if (cmd.seed)
        begin
            b_fresh = assc_pkg::COUNT_W'(1);
        end
        else
        begin
            b_fresh = assc_pkg::mod_add(a_t_reg, a_p_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg <= assc_pkg::MAX_VALUE_RESET;
            rd_active_reg <= 1'b0;
            rd_idx_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            a_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_value_reg <= cfg_wdata;
            end

            if (cmd.start)
            begin
                rd_active_reg <= 1'b1;
                rd_idx_reg    <= '0;
            end
            else if (rd_active_reg)
            begin
                rd_idx_reg <= rd_idx_reg + BW'(1);
                if (rd_idx_reg == BW'(MAX_VALUE))
                begin
                    rd_active_reg <= 1'b0;
                end
            end

            s1_valid_reg <= rd_active_reg;
            a_valid_reg  <= s1_valid_reg && (s1_idx_reg >= BW'(1));
            c_valid_reg  <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_active_reg && (rd_idx_reg < BW'(MAX_VALUE)))
        begin
            rdata_reg <= mem[rd_idx_reg[AW-1:0]];
        end
        if (a_valid_reg)
        begin
            mem[a_j_reg] <= b_fresh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            fixed_reg <= template_value;
            bound_reg <= bound_now;
            total_reg <= '0;
        end
        else if (c_valid_reg)
        begin
            total_reg <= assc_pkg::mod_add(total_reg, c_fresh_reg);
        end

        s1_idx_reg <= rd_idx_reg;

        if (s1_valid_reg)
        begin
            cur_reg  <= rdata_reg;
            prev_reg <= cur_reg;
            a_j_reg  <= AW'(s1_idx_reg - BW'(1));
            a_t_reg  <= assc_pkg::mod_add(cur_reg,
                                          (s1_idx_reg < bound_reg) ? rdata_reg : '0);
            a_p_reg  <= (s1_idx_reg >= BW'(2)) ? prev_reg : '0;
        end

        c_fresh_reg <= b_fresh;
        c_last_reg  <= (a_j_reg == AW'(MAX_VALUE - 1));

        if (cmd.load_out)
        begin
            count_out_reg <= total_reg;
        end
    end

    assign status.done = c_valid_reg && c_last_reg;
    assign array_count = count_out_reg;

    `ASSC_ASSERT_NEXT(a_total_reduced, c_valid_reg, total_reg < assc_pkg::COUNT_MOD,
        "running total left the residue range")
    `ASSC_ASSERT_NOW(a_no_start_mid_sweep, !(cmd.start && (rd_active_reg || a_valid_reg)),
        "new item started while a sweep was still running")

endmodule

/* hdl/assc_ctrl.sv */
// Controller state machine: item acceptance, sweep tracking and result register.
`include "adjacent_step_sequence_counter_top_macros.svh"

module assc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output assc_pkg::cmd_t     cmd,
    input  assc_pkg::status_t  status
);

    typedef enum logic [1:0] {
        IDLE,
        SWEEP,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   last_reg;
    logic   at_start_reg;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    assign s_tready     = (state_reg == IDLE);
    assign cmd.start    = (state_reg == IDLE) && s_tvalid;
    assign cmd.seed     = at_start_reg;
    assign cmd.load_out = (state_reg == FINISH) && last_reg && (!m_tvalid_reg || m_tready);
    assign m_tvalid     = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = SWEEP;
                end
            end
            SWEEP:
            begin
                if (status.done)
                begin
                    state_next = FINISH;
                end
            end
            FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = IDLE;
                end
                else if (cmd.load_out)
                begin
                    state_next    = IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            last_reg     <= 1'b0;
            at_start_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cmd.start)
            begin
                last_reg <= s_tlast;
            end
            if ((state_reg == FINISH) && (state_next == IDLE))
            begin
                at_start_reg <= last_reg;
            end
        end
    end

    `ASSC_ASSERT_NOW(a_done_in_sweep, !status.done || (state_reg == SWEEP),
        "sweep completion seen outside the sweep state")
    `ASSC_ASSERT_NOW(a_load_slot_free, !cmd.load_out || !m_tvalid_reg || m_tready,
        "result loaded over a beat not yet taken")
    `ASSC_ASSERT_NEXT(a_start_enters_sweep, cmd.start, state_reg == SWEEP,
        "accepted beat did not start a sweep")

endmodule

/* hdl/adjacent_step_sequence_counter_top.sv */
// Top level of the adjacent step sequence counter.
//
// Input beats carry one template element each: s_tdata[7:0] is the element
// (zero means free, otherwise the fixed value) and s_tlast marks the final
// element of an array. On the last element the block returns one output beat
// whose m_tdata[29:0] holds the number of matching arrays modulo 1000000007.
// The register max_value is written through cfg_we and cfg_wdata while idle;
// the user is bound to this, as the block itself does not enforce it. Each
// element sweeps all MAX_VALUE count entries through one read and one write
// port of the count memory, so the next element is taken only after the
// sweep of the previous one is done. The result beat is presented after the
// last element's final count entry is written and the total is updated.
// A stalled result waits in its output register while the next element is
// accepted and swept; a following result then waits until the previous one is
// taken. Reset clears the control state, sets max_value to 100 and starts a
// fresh array; the count memory needs no clearing because the first element
// of an array rewrites every entry.
module adjacent_step_sequence_counter_top #(
    parameter int MAX_VALUE = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,      // max_value
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] template_value
    input  logic        s_tlast,        // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata         // [29:0] array_count, [31:30] zero
);

    assc_pkg::cmd_t               cmd;
    assc_pkg::status_t            status;
    logic [assc_pkg::COUNT_W-1:0] array_count;

    assc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    assc_datapath #(
        .MAX_VALUE (MAX_VALUE)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .template_value (s_tdata),
        .cmd            (cmd),
        .status         (status),
        .array_count    (array_count)
    );

    assign m_tdata = {(assc_pkg::OUT_TDATA_W - assc_pkg::COUNT_W)'(0), array_count};

endmodule
